FILE: rtl/tte_pkg.sv
// Package for the timestamp text to epoch block: record types, status codes,
// character codes, text positions and the calendar tables.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package tte_pkg;

    // Result status, in the order the checks are made.
    typedef enum logic [2:0] {
        ST_OK,
        ST_FORMAT,
        ST_MONTH,
        ST_DAY,
        ST_HOUR,
        ST_MINUTE,
        ST_SECOND
    } status_t;

    // Back-end sequencer steps.
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_YEAR,
        BK_DAYS,
        BK_HOURS,
        BK_MINUTES,
        BK_DONE
    } bk_state_t;

    // One parsed timestamp handed from the parser to the converter.
    typedef struct packed {
        status_t     status;
        logic [13:0] year;
        logic [6:0]  month;
        logic [6:0]  day;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
        logic [29:0] fraction;
        logic [3:0]  frac_count;
    } ts_rec_t;

    localparam int FRACTION_DIGITS = 9;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QUEUE_AW        = $clog2(QUEUE_DEPTH);
    localparam int DAYS_TO_1970    = 719528;

    // Character codes.
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_DASH  = 8'd45;
    localparam logic [7:0] CH_COLON = 8'd58;
    localparam logic [7:0] CH_DOT   = 8'd46;
    localparam logic [7:0] CH_T     = 8'd84;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;

    // Character positions within the text.
    localparam logic [4:0] POS_YEAR_END  = 5'd4;
    localparam logic [4:0] POS_DASH1     = 5'd4;
    localparam logic [4:0] POS_MONTH0    = 5'd5;
    localparam logic [4:0] POS_MONTH1    = 5'd6;
    localparam logic [4:0] POS_DASH2     = 5'd7;
    localparam logic [4:0] POS_DAY0      = 5'd8;
    localparam logic [4:0] POS_DAY1      = 5'd9;
    localparam logic [4:0] POS_SEP       = 5'd10;
    localparam logic [4:0] POS_HOUR0     = 5'd11;
    localparam logic [4:0] POS_HOUR1     = 5'd12;
    localparam logic [4:0] POS_COLON1    = 5'd13;
    localparam logic [4:0] POS_MINUTE0   = 5'd14;
    localparam logic [4:0] POS_MINUTE1   = 5'd15;
    localparam logic [4:0] POS_COLON2    = 5'd16;
    localparam logic [4:0] POS_SECOND0   = 5'd17;
    localparam logic [4:0] POS_SECOND1   = 5'd18;
    localparam logic [4:0] POS_FRAC      = 5'd19;
    localparam logic [4:0] POS_MAX       = 5'd31;

    // Days in the common year before the first of the month (1-12).
    function automatic logic [8:0] days_before_month(input logic [3:0] month);
        logic [8:0] days;
        unique case (month)
            4'd1:    days = 9'd0;
            4'd2:    days = 9'd31;
            4'd3:    days = 9'd59;
            4'd4:    days = 9'd90;
            4'd5:    days = 9'd120;
            4'd6:    days = 9'd151;
            4'd7:    days = 9'd181;
            4'd8:    days = 9'd212;
            4'd9:    days = 9'd243;
            4'd10:   days = 9'd273;
            4'd11:   days = 9'd304;
            4'd12:   days = 9'd334;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

    // Scale that pads a fraction of the given digit count to nine digits.
    function automatic logic [29:0] pad_scale(input logic [3:0] count);
        logic [29:0] scale;
        unique case (count)
            4'd0:    scale = 30'd1000000000;
            4'd1:    scale = 30'd100000000;
            4'd2:    scale = 30'd10000000;
            4'd3:    scale = 30'd1000000;
            4'd4:    scale = 30'd100000;
            4'd5:    scale = 30'd10000;
            4'd6:    scale = 30'd1000;
            4'd7:    scale = 30'd100;
            4'd8:    scale = 30'd10;
            default: scale = 30'd1;
        endcase
        return scale;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/tte_parse.sv
// Front end: takes one text character per beat, checks the layout and
// accumulates the date, time and fraction fields; emits a record on the last beat.
// Depends on tte_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tte_parse (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire logic [7:0]      char_code,
    input  wire logic            last_char,
    input  wire logic            q_full,
    output logic                 in_ready,
    output logic                 push,
    output tte_pkg::ts_rec_t     push_rec
);

    logic [4:0]  pos_reg,    pos_next;
    logic [13:0] year_reg,   year_next;
    logic [6:0]  month_reg,  month_next;
    logic [6:0]  day_reg,    day_next;
    logic [6:0]  hour_reg,   hour_next;
    logic [6:0]  minute_reg, minute_next;
    logic [6:0]  second_reg, second_next;
    logic [29:0] frac_reg,   frac_next;
    logic [3:0]  fcount_reg, fcount_next;
    logic        ferr_reg,   ferr_next;

    logic        is_digit;
    logic        is_sep;
    logic [3:0]  dval;
    logic [29:0] year_push, month_push, day_push, hour_push;
    logic [29:0] minute_push, second_push, frac_push;
    logic        accept;
    tte_pkg::status_t status;

    function automatic logic [29:0] push_digit(input logic [29:0] acc, input logic [3:0] d);
        return (acc << 3) + (acc << 1) + {26'b0, d};
    endfunction

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign push     = accept && last_char;

    assign is_digit = (char_code >= tte_pkg::CH_ZERO) && (char_code <= tte_pkg::CH_NINE);
    assign dval     = is_digit ? 4'(char_code - tte_pkg::CH_ZERO) : 4'd0;
    assign is_sep   = (char_code == tte_pkg::CH_T) || (char_code == tte_pkg::CH_SPACE) ||
                      ((char_code >= tte_pkg::CH_TAB) && (char_code <= tte_pkg::CH_CR));

    assign year_push   = push_digit({16'b0, year_reg}, dval);
    assign month_push  = push_digit({23'b0, month_reg}, dval);
    assign day_push    = push_digit({23'b0, day_reg}, dval);
    assign hour_push   = push_digit({23'b0, hour_reg}, dval);
    assign minute_push = push_digit({23'b0, minute_reg}, dval);
    assign second_push = push_digit({23'b0, second_reg}, dval);
    assign frac_push   = push_digit(frac_reg, dval);

    always_comb
    begin
        year_next   = year_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        frac_next   = frac_reg;
        fcount_next = fcount_reg;
        ferr_next   = ferr_reg;
        priority if (pos_reg < tte_pkg::POS_YEAR_END)
        begin
            if (is_digit) year_next = year_push[13:0]; else ferr_next = 1'b1;
        end
        else if (pos_reg == tte_pkg::POS_DASH1 || pos_reg == tte_pkg::POS_DASH2)
        begin
            if (char_code != tte_pkg::CH_DASH) ferr_next = 1'b1;
        end
        else if (pos_reg == tte_pkg::POS_MONTH0 || pos_reg == tte_pkg::POS_MONTH1)
        begin
            if (is_digit) month_next = month_push[6:0]; else ferr_next = 1'b1;
        end
        else if (pos_reg == tte_pkg::POS_DAY0 || pos_reg == tte_pkg::POS_DAY1)
        begin
            if (is_digit) day_next = day_push[6:0]; else ferr_next = 1'b1;
        end
        else if (pos_reg == tte_pkg::POS_SEP)
        begin
            if (!is_sep) ferr_next = 1'b1;
        end
        else if (pos_reg == tte_pkg::POS_HOUR0 || pos_reg == tte_pkg::POS_HOUR1)
        begin
            if (is_digit) hour_next = hour_push[6:0]; else ferr_next = 1'b1;
        end
        else if (pos_reg == tte_pkg::POS_COLON1 || pos_reg == tte_pkg::POS_COLON2)
        begin
            if (char_code != tte_pkg::CH_COLON) ferr_next = 1'b1;
        end
        else if (pos_reg == tte_pkg::POS_MINUTE0 || pos_reg == tte_pkg::POS_MINUTE1)
        begin
            if (is_digit) minute_next = minute_push[6:0]; else ferr_next = 1'b1;
        end
        else if (pos_reg == tte_pkg::POS_SECOND0 || pos_reg == tte_pkg::POS_SECOND1)
        begin
            if (is_digit) second_next = second_push[6:0]; else ferr_next = 1'b1;
        end
        else
        begin
            // The optional dot is only legal right after the seconds.
            if (char_code == tte_pkg::CH_DOT && pos_reg == tte_pkg::POS_FRAC)
            begin
                ferr_next = ferr_reg;
            end
            else if (is_digit && fcount_reg < 4'(tte_pkg::FRACTION_DIGITS))
            begin
                frac_next   = frac_push;
                fcount_next = fcount_reg + 4'd1;
            end
            else
            begin
                ferr_next = 1'b1;
            end
        end
        pos_next = (pos_reg != tte_pkg::POS_MAX) ? pos_reg + 5'd1 : pos_reg;
    end

    always_comb
    begin
        priority if (ferr_next || pos_next < tte_pkg::POS_FRAC)
            status = tte_pkg::ST_FORMAT;
        else if (month_next < 7'd1 || month_next > 7'd12)
            status = tte_pkg::ST_MONTH;
        else if (day_next < 7'd1 || day_next > 7'd31)
            status = tte_pkg::ST_DAY;
        else if (hour_next > 7'd23)
            status = tte_pkg::ST_HOUR;
        else if (minute_next > 7'd59)
            status = tte_pkg::ST_MINUTE;
        else if (second_next > 7'd59)
            status = tte_pkg::ST_SECOND;
        else
            status = tte_pkg::ST_OK;
    end

    always_comb
    begin
        push_rec.status     = status;
        push_rec.year       = year_next;
        push_rec.month      = month_next;
        push_rec.day        = day_next;
        push_rec.hour       = hour_next;
        push_rec.minute     = minute_next;
        push_rec.second     = second_next;
        push_rec.fraction   = frac_next;
        push_rec.frac_count = fcount_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            year_reg   <= '0;
            month_reg  <= '0;
            day_reg    <= '0;
            hour_reg   <= '0;
            minute_reg <= '0;
            second_reg <= '0;
            frac_reg   <= '0;
            fcount_reg <= '0;
            ferr_reg   <= 1'b0;
        end
        else if (accept)
        begin
            if (last_char)
            begin
                pos_reg    <= '0;
                year_reg   <= '0;
                month_reg  <= '0;
                day_reg    <= '0;
                hour_reg   <= '0;
                minute_reg <= '0;
                second_reg <= '0;
                frac_reg   <= '0;
                fcount_reg <= '0;
                ferr_reg   <= 1'b0;
            end
            else
            begin
                pos_reg    <= pos_next;
                year_reg   <= year_next;
                month_reg  <= month_next;
                day_reg    <= day_next;
                hour_reg   <= hour_next;
                minute_reg <= minute_next;
                second_reg <= second_next;
                frac_reg   <= frac_next;
                fcount_reg <= fcount_next;
                ferr_reg   <= ferr_next;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/tte_queue.sv
// Short record queue between the parser and the converter.
// Depends on tte_pkg for the record type and depth.
`timescale 1ns / 1ps
`default_nettype none

module tte_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire tte_pkg::ts_rec_t  push_rec,
    output logic                   full,
    input  wire logic              pop,
    output logic                   not_empty,
    output tte_pkg::ts_rec_t       pop_rec
);

    tte_pkg::ts_rec_t              mem_reg [tte_pkg::QUEUE_DEPTH];
    logic [tte_pkg::QUEUE_AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [tte_pkg::QUEUE_AW:0]    count_reg;

    assign full      = (count_reg == (tte_pkg::QUEUE_AW + 1)'(tte_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_rec   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
            mem_reg[wr_ptr_reg] <= push_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push && !full)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop && not_empty)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            unique case ({push && !full, pop && not_empty})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/tte_convert.sv
// Back end: turns one parsed record into signed Unix seconds and nanoseconds
// over a short step sequence of multiplications and sums.
// Depends on tte_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tte_convert (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              rec_valid,
    input  wire tte_pkg::ts_rec_t  rec_in,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [2:0]             status,
    output logic signed [38:0]     epoch_seconds,
    output logic [29:0]            nanoseconds
);

    tte_pkg::bk_state_t state_reg, state_next;
    tte_pkg::ts_rec_t   rec_reg;

    logic [22:0]        y365_reg;
    logic [12:0]        q4_reg;
    logic [7:0]         q100_reg;
    logic [5:0]         q400_reg;
    logic [29:0]        nanos_reg;
    logic signed [23:0] days_reg;
    logic signed [38:0] secs_reg;

    logic               out_valid_reg;
    logic [2:0]         out_status_reg;
    logic signed [38:0] out_secs_reg;
    logic [29:0]        out_nanos_reg;

    logic               slot_free;
    logic               do_year, do_days, do_hours, do_minutes, do_done;

    logic [14:0]        y_plus3, y_plus99, y_plus399;
    logic [27:0]        q100_prod;
    logic [15:0]        q400_prod;
    logic [59:0]        nanos_prod;
    logic               leap;
    logic [24:0]        days_sum;
    logic signed [38:0] secs_final;

    assign slot_free = !out_valid_reg || out_ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tte_pkg::BK_IDLE:    if (rec_valid) state_next = tte_pkg::BK_YEAR;
            tte_pkg::BK_YEAR:    state_next = tte_pkg::BK_DAYS;
            tte_pkg::BK_DAYS:    state_next = tte_pkg::BK_HOURS;
            tte_pkg::BK_HOURS:   state_next = tte_pkg::BK_MINUTES;
            tte_pkg::BK_MINUTES: state_next = tte_pkg::BK_DONE;
            tte_pkg::BK_DONE:    if (slot_free) state_next = tte_pkg::BK_IDLE;
            default:             state_next = tte_pkg::BK_IDLE;
        endcase
    end

    // Step enables.
    always_comb
    begin
        pop        = 1'b0;
        do_year    = 1'b0;
        do_days    = 1'b0;
        do_hours   = 1'b0;
        do_minutes = 1'b0;
        do_done    = 1'b0;
        unique case (state_reg)
            tte_pkg::BK_IDLE:    pop        = rec_valid;
            tte_pkg::BK_YEAR:    do_year    = 1'b1;
            tte_pkg::BK_DAYS:    do_days    = 1'b1;
            tte_pkg::BK_HOURS:   do_hours   = 1'b1;
            tte_pkg::BK_MINUTES: do_minutes = 1'b1;
            tte_pkg::BK_DONE:    do_done    = slot_free;
            default:             pop        = 1'b0;
        endcase
    end

    // Leap days up to a year: ceil(y/4) - ceil(y/100) + ceil(y/400); the
    // divisions by 100 and 400 are reciprocal multiplies, exact for every
    // four-digit year.
    assign y_plus3    = {1'b0, rec_reg.year} + 15'd3;
    assign y_plus99   = {1'b0, rec_reg.year} + 15'd99;
    assign y_plus399  = {1'b0, rec_reg.year} + 15'd399;
    assign q100_prod  = {13'b0, y_plus99} * 28'd5243;
    assign q400_prod  = {5'b0, y_plus399[14:4]} * 16'd41;
    assign nanos_prod = {30'b0, rec_reg.fraction} *
                        {30'b0, tte_pkg::pad_scale(rec_reg.frac_count)};

    // A year is divisible by 100 (or 400) exactly when its ceiling quotient
    // times the divisor gives the year back.
    assign leap = (rec_reg.year[1:0] == 2'b00) &&
                  ((({6'b0, q100_reg} * 14'd100) != rec_reg.year) ||
                   (({8'b0, q400_reg} * 14'd400) == rec_reg.year));

    assign days_sum = 25'(y365_reg) + 25'(q4_reg) - 25'(q100_reg) + 25'(q400_reg)
                    + 25'(tte_pkg::days_before_month(rec_reg.month[3:0]))
                    + 25'(leap && (rec_reg.month > 7'd2))
                    + 25'(rec_reg.day) - 25'(tte_pkg::DAYS_TO_1970 + 1);

    assign secs_final = secs_reg * 39'sd60 + $signed({32'b0, rec_reg.second});

    always_ff @(posedge clk)
    begin
        if (pop)
            rec_reg <= rec_in;
        if (do_year)
        begin
            y365_reg  <= {9'b0, rec_reg.year} * 23'd365;
            q4_reg    <= y_plus3[14:2];
            q100_reg  <= q100_prod[26:19];
            q400_reg  <= q400_prod[15:10];
            nanos_reg <= nanos_prod[29:0];
        end
        if (do_days)
            days_reg <= $signed(days_sum[23:0]);
        if (do_hours)
            secs_reg <= 39'(days_reg) * 39'sd24 + $signed({32'b0, rec_reg.hour});
        if (do_minutes)
            secs_reg <= secs_reg * 39'sd60 + $signed({32'b0, rec_reg.minute});
        if (do_done)
        begin
            out_status_reg <= rec_reg.status;
            if (rec_reg.status == tte_pkg::ST_OK)
            begin
                out_secs_reg  <= secs_final;
                out_nanos_reg <= nanos_reg;
            end
            else
            begin
                out_secs_reg  <= '0;
                out_nanos_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tte_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (do_done)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign epoch_seconds = out_secs_reg;
    assign nanoseconds   = out_nanos_reg;

endmodule

`default_nettype wire

FILE: rtl/timestamp_text_to_epoch.sv
// Top level of the timestamp text to Unix time converter: parser front end,
// record queue and conversion back end. Depends on tte_pkg, tte_parse,
// tte_queue and tte_convert.
//
//   Channel  Dir  Fields (tdata from bit 0 up)                    Ends beat on
//   s_axis   in   tdata: char_code[7:0]; tlast: last_char         s_tvalid & s_tready
//   m_axis   out  tdata: status[2:0], epoch_seconds[41:3],        m_tvalid & m_tready
//                        nanoseconds[71:42]
//
// The parser takes one character beat per cycle while the queue has room.
// The converter then works through one timestamp at a time: record load,
// year terms, day count, hours, minutes, then seconds with the output load;
// it overlaps the parsing of the next text through a two-record queue.
// s_tready drops only while the queue is full, so a stalled output backs up
// through the converter and the queue before the input side stalls. Reset
// is asynchronous and active low; it empties the queue and returns the
// parser to the first character position.
`timescale 1ns / 1ps
`default_nettype none

module timestamp_text_to_epoch (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_code
    input  wire logic        s_tlast,   // last_char
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata    // [2:0] status, [41:3] epoch_seconds,
                                        // [71:42] nanoseconds
);

    // Parser to queue.
    logic              fr_push;
    tte_pkg::ts_rec_t  fr_rec;
    logic              q_full;

    // Queue to converter.
    logic              q_not_empty;
    logic              q_pop;
    tte_pkg::ts_rec_t  q_rec;

    // Converter results.
    logic [2:0]         res_status;
    logic signed [38:0] res_seconds;
    logic [29:0]        res_nanos;

    tte_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .char_code (s_tdata),
        .last_char (s_tlast),
        .q_full    (q_full),
        .in_ready  (s_tready),
        .push      (fr_push),
        .push_rec  (fr_rec)
    );

    tte_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fr_push),
        .push_rec  (fr_rec),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_rec   (q_rec)
    );

    tte_convert u_convert (
        .clk           (clk),
        .rst_n         (rst_n),
        .rec_valid     (q_not_empty),
        .rec_in        (q_rec),
        .pop           (q_pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .status        (res_status),
        .epoch_seconds (res_seconds),
        .nanoseconds   (res_nanos)
    );

    // Result beat: status in the low bits, then seconds, then nanoseconds.
    assign m_tdata = {res_nanos, res_seconds, res_status};

`ifndef NO_ASSERTIONS
    // The parser only hands over a record when the queue has room for it.
    assert property (@(posedge clk) disable iff (!rst_n) fr_push |-> !q_full)
        else $error("record pushed into a full queue");

    // The converter only pops a record that is present.
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_not_empty)
        else $error("record popped from an empty queue");

    // Any failing status carries zero times.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (res_status != tte_pkg::ST_OK)) |-> (m_tdata[71:3] == '0))
        else $error("error result with nonzero time fields");

    // A good result has a fraction below one second.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (res_status == tte_pkg::ST_OK)) |-> (res_nanos < 30'd1000000000))
        else $error("nanoseconds out of range");
`endif

endmodule

`default_nettype wire
